// ===== src/controller_packet_responder_core_macros.svh =====
// Assertion macros for the responder RTL; cpr_back uses them.
// Depends on nothing; files that assert include it by name.
`ifndef CONTROLLER_PACKET_RESPONDER_CORE_MACROS_SVH
`define CONTROLLER_PACKET_RESPONDER_CORE_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define CPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that a condition never occurs outside reset.
`define CPR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/cpr_pkg.sv =====
// Types, constants and the device-info table for the packet responder.
// Used by every module of the block.
package cpr_pkg;

  localparam logic [5:0]  DevAddrReset  = 6'd32;
  localparam logic [31:0] ButtonsReset  = 32'h000F06FE;
  localparam logic [10:0] CountMax      = 11'd2047;
  localparam logic [7:0]  PortBits      = 8'hC0;
  localparam logic [7:0]  PeriphBits    = 8'h3F;
  localparam logic [7:0]  AxisCentre    = 8'd128;
  localparam logic [31:0] FuncStatus    = 32'd1;
  localparam logic [31:0] FuncRumble    = 32'd256;
  localparam logic [31:0] FuncWord      = 32'h01000000;

  localparam logic [7:0] CmdDevReq  = 8'd1;
  localparam logic [7:0] CmdReset   = 8'd3;
  localparam logic [7:0] CmdGetCond = 8'd9;
  localparam logic [7:0] CmdSetCond = 8'd14;
  localparam logic [7:0] CmdInfo    = 8'd5;
  localparam logic [7:0] CmdAck     = 8'd7;
  localparam logic [7:0] CmdStatus  = 8'd8;

  localparam logic [0:0] RegDevAddr = 1'b0;
  localparam logic [0:0] RegButtons = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK,
    KIND_INFO,
    KIND_STATUS
  } reply_kind_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  bus_byte;
    logic        last_byte;
    logic [15:0] buttons;
    logic [7:0]  right_trigger;
    logic [7:0]  left_trigger;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic [7:0]  stick2_x;
    logic [7:0]  stick2_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] tx_word;
    logic        last_word;
    logic [7:0]  rumble_power;
  } out_item_t;

  // One reply as handed from the front to the back.
  typedef struct packed {
    reply_kind_e kind;
    logic [31:0] head;
    logic [31:0] stat_a;
    logic [31:0] stat_b;
    logic [7:0]  rumble;
  } reply_t;

  function automatic logic [31:0] swap32(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] info_word(logic [4:0] k);
    logic [31:0] w;
    unique case (k)
      5'd0:  w = 32'h724400FF;
      5'd1:  w = 32'h636D6165;
      5'd2:  w = 32'h20747361;
      5'd3:  w = 32'h746E6F43;
      5'd4:  w = 32'h6C6C6F72;
      5'd5:  w = 32'h20207265;
      5'd6:  w = 32'h20202020;
      5'd7:  w = 32'h20202020;
      5'd8:  w = 32'h646F7250;
      5'd9:  w = 32'h64656375;
      5'd10: w = 32'h20794220;
      5'd11: w = 32'h5520726F;
      5'd12: w = 32'h7265646E;
      5'd13: w = 32'h63694C20;
      5'd14: w = 32'h65736E65;
      5'd15: w = 32'h6F724620;
      5'd16: w = 32'h4553206D;
      5'd17: w = 32'h45204147;
      5'd18: w = 32'h5245544E;
      5'd19: w = 32'h53495250;
      5'd20: w = 32'h4C2C5345;
      5'd21: w = 32'h202E4454;
      5'd22: w = 32'h20202020;
      5'd23: w = 32'h01F401AE;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/controller_packet_responder_core.sv =====
// Packet responder: one input item per cycle while the reply queue has room.
// A valid packet end writes its reply into the queue; the back sequencer loads it
// and registers one word per cycle as results are popped: 3, 6 or 31 words.
// Reset clears counters, queue and output valid; controller state to released and
// centered; config to address 32 and the default button mask.
module controller_packet_responder_core import cpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [5:0]  dev_addr_q;
  logic [31:0] buttons_q;
  logic        accept, f_push, q_empty, q_pop;
  reply_t      f_rep, q_rep;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
      buttons_q  <= ButtonsReset;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        RegDevAddr: dev_addr_q <= cfg_data_i[5:0];
        RegButtons: buttons_q  <= cfg_data_i;
        default:    dev_addr_q <= dev_addr_q;
      endcase
    end
  end

  cpr_front u_front (
    .clk_i, .rst_ni,
    .accept_i(accept), .item_i(in_i), .dev_addr_i(dev_addr_q),
    .push_o(f_push), .reply_o(f_rep)
  );

  cpr_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(f_push), .data_i(f_rep), .full_o(full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_rep)
  );

  cpr_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_data_i(q_rep), .q_pop_o(q_pop),
    .buttons_sup_i(buttons_q),
    .pop_i(pop), .empty_o(empty), .out_o(out_o)
  );

endmodule

// ===== src/cpr_front.sv =====
// Front end: byte reception, packet checks and reply classification.
// Depends on cpr_pkg.
module cpr_front import cpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  in_item_t   item_i,
  input  logic [5:0] dev_addr_i,
  output logic       push_o,
  output reply_t     reply_o
);

  logic [10:0] cnt_q, cnt_d, size;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  hdr_q [4];
  logic [31:0] func_q;
  logic [7:0]  cond_q;
  logic [15:0] btn_q;
  logic [7:0]  axes_q [6];
  logic [7:0]  rumble_q, rumble_d;
  logic [31:0] head_port;
  logic [7:0]  port, org;
  logic        pkt_ok, is_byte, pkt_end;

  assign is_byte = accept_i && !item_i.opcode;
  assign pkt_end = is_byte && item_i.last_byte;
  assign xor_d   = xor_q ^ item_i.bus_byte;
  assign size    = (cnt_q == CountMax) ? cnt_q : cnt_q + 11'd1;
  assign cnt_d   = pkt_end ? 11'd0 : size;

  assign port = hdr_q[1] & PortBits;
  assign org  = {2'b00, dev_addr_i} | port;
  assign head_port = {8'h00, org, port, 8'h00};

  assign pkt_ok = (xor_d == 8'h00) && (size[1:0] == 2'b01)
               && ((size - 11'd1) == (({3'b000, hdr_q[0]} + 11'd1) << 2))
               && ((hdr_q[2] & PeriphBits) == {2'b00, dev_addr_i});

  always_comb begin
    push_o   = 1'b0;
    rumble_d = rumble_q;
    reply_o.kind   = KIND_ACK;
    reply_o.head   = head_port | {24'h0, CmdAck};
    reply_o.stat_a = {axes_q[1], axes_q[0], btn_q};
    reply_o.stat_b = {axes_q[5], axes_q[4], axes_q[3], axes_q[2]};
    if (pkt_end && pkt_ok) begin
      unique case (hdr_q[3])
        CmdReset: push_o = 1'b1;
        CmdDevReq: begin
          push_o       = 1'b1;
          reply_o.kind = KIND_INFO;
          reply_o.head = head_port | {8'd28, 16'h0, CmdInfo};
        end
        CmdGetCond: begin
          push_o       = (hdr_q[0] != 8'd0) && (func_q == FuncStatus);
          reply_o.kind = KIND_STATUS;
          reply_o.head = head_port | {8'd3, 16'h0, CmdStatus};
        end
        CmdSetCond: begin
          push_o = 1'b1;
          if (hdr_q[0] >= 8'd2 && func_q == FuncRumble) begin
            rumble_d = cond_q;
          end
        end
        default: push_o = 1'b0;
      endcase
    end
    reply_o.rumble = rumble_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 11'd0;
      xor_q    <= 8'd0;
      btn_q    <= 16'hFFFF;
      axes_q   <= '{8'd0, 8'd0, AxisCentre, AxisCentre, AxisCentre, AxisCentre};
      rumble_q <= 8'd0;
    end else begin
      rumble_q <= rumble_d;
      if (is_byte) begin
        cnt_q <= cnt_d;
        xor_q <= pkt_end ? 8'd0 : xor_d;
      end
      if (accept_i && item_i.opcode) begin
        btn_q  <= item_i.buttons;
        axes_q <= '{item_i.right_trigger, item_i.left_trigger, item_i.stick_x,
                    item_i.stick_y, item_i.stick2_x, item_i.stick2_y};
      end
    end
  end

  // Header, function word and condition byte capture.
  always_ff @(posedge clk_i) begin
    if (is_byte) begin
      if (cnt_q < 11'd4) begin
        hdr_q[cnt_q[1:0]] <= item_i.bus_byte;
      end else if (cnt_q < 11'd8) begin
        func_q[{cnt_q[1:0], 3'b000} +: 8] <= item_i.bus_byte;
      end else if (cnt_q == 11'd10) begin
        cond_q <= item_i.bus_byte;
      end
    end
  end

endmodule

// ===== src/cpr_queue.sv =====
// Two-entry reply queue between front and back.
// Depends on cpr_pkg.
module cpr_queue import cpr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  reply_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output reply_t data_o
);

  reply_t      mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== src/cpr_back.sv =====
// Back end: walks one reply word per cycle into the output register while it is free or popped.
// Depends on cpr_pkg and the assertion macros.
`include "controller_packet_responder_core_macros.svh"
module cpr_back import cpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  reply_t      q_data_i,
  output logic        q_pop_o,
  input  logic [31:0] buttons_sup_i,
  input  logic        pop_i,
  output logic        empty_o,
  output out_item_t   out_o
);

  logic        busy_q, oval_q;
  reply_t      rep_q;
  logic [4:0]  idx_q, last_idx;
  logic [31:0] x_q, fold, word;
  logic        advance, is_last;
  out_item_t   out_q;

  assign q_pop_o = !busy_q && !q_empty_i;
  assign advance = busy_q && (!oval_q || pop_i);
  assign empty_o = !oval_q;
  assign out_o   = out_q;

  always_comb begin
    unique case (rep_q.kind)
      KIND_INFO:   last_idx = 5'd30;
      KIND_STATUS: last_idx = 5'd5;
      default:     last_idx = 5'd2;
    endcase
  end

  assign is_last = (idx_q == last_idx);
  assign fold    = (x_q ^ (x_q << 16)) ^ ((x_q ^ (x_q << 16)) << 8);

  always_comb begin
    word = 32'h0;
    if (is_last) begin
      word = fold;
    end else if (idx_q == 5'd0) begin
      unique case (rep_q.kind)
        KIND_INFO:   word = 32'd467;
        KIND_STATUS: word = 32'd67;
        default:     word = 32'd19;
      endcase
    end else if (idx_q == 5'd1) begin
      word = rep_q.head;
    end else if (idx_q == 5'd2) begin
      word = FuncWord;
    end else if (rep_q.kind == KIND_STATUS) begin
      word = (idx_q == 5'd3) ? rep_q.stat_a : rep_q.stat_b;
    end else if (idx_q == 5'd3) begin
      word = swap32(buttons_sup_i);
    end else if (idx_q >= 5'd6) begin
      word = info_word(idx_q - 5'd6);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
      idx_q  <= 5'd0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 5'd0;
      end else if (advance) begin
        idx_q <= idx_q + 5'd1;
        if (is_last) busy_q <= 1'b0;
      end
      if (advance)    oval_q <= 1'b1;
      else if (pop_i) oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rep_q <= q_data_i;
      x_q   <= 32'h0;
    end else if (advance) begin
      if (idx_q != 5'd0) x_q <= x_q ^ word;
    end
    if (advance) begin
      out_q <= '{tx_word: word, last_word: is_last, rumble_power: rep_q.rumble};
    end
  end

  `CPR_ASSERT(a_last_ends, advance && is_last |=> !busy_q, "reply did not end on last word")
  `CPR_ASSERT(a_idx_bound, busy_q |-> idx_q <= last_idx, "word index past end of reply")
  `CPR_ASSERT_NEVER(a_no_load_busy, q_pop_o && (busy_q || advance), "reply loaded while busy")
  `CPR_ASSERT(a_hold_out, !empty_o && !pop_i |=> !empty_o && $stable(out_o), "result not held")

endmodule

// ===== test/tb.sv =====
// Testbench for controller_packet_responder_core: builds bus packets and
// controller updates, predicts every reply word and checks it on pop.
// Depends on cpr_pkg and the responder RTL.
module tb;
  import cpr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  typedef logic [31:0] word_q_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  int  err_count = 0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  controller_packet_responder_core DUT (.*);

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Device-info text words, written out here independently of the package.
  function automatic logic [31:0] info_q(int k);
    byte unsigned t[96];
    t = '{8'hFF, 8'h00,
          8'h44, 8'h72, 8'h65, 8'h61, 8'h6D, 8'h63, 8'h61, 8'h73, 8'h74, 8'h20,
          8'h43, 8'h6F, 8'h6E, 8'h74, 8'h72, 8'h6F, 8'h6C, 8'h6C, 8'h65, 8'h72,
          8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
          8'h50, 8'h72, 8'h6F, 8'h64, 8'h75, 8'h63, 8'h65, 8'h64, 8'h20, 8'h42,
          8'h79, 8'h20, 8'h6F, 8'h72, 8'h20, 8'h55, 8'h6E, 8'h64, 8'h65, 8'h72,
          8'h20, 8'h4C, 8'h69, 8'h63, 8'h65, 8'h6E, 8'h73, 8'h65, 8'h20, 8'h46,
          8'h72, 8'h6F, 8'h6D, 8'h20, 8'h53, 8'h45, 8'h47, 8'h41, 8'h20, 8'h45,
          8'h4E, 8'h54, 8'h45, 8'h52, 8'h50, 8'h52, 8'h49, 8'h53, 8'h45, 8'h53,
          8'h2C, 8'h4C, 8'h54, 8'h44, 8'h2E, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
          8'hAE, 8'h01, 8'hF4, 8'h01};
    return {t[4*k+3], t[4*k+2], t[4*k+1], t[4*k]};
  endfunction

  function automatic word_q_t info_text();
    word_q_t q;
    for (int k = 0; k < 24; k++) q.push_back(info_q(k));
    return q;
  endfunction

  // Packet responder predictor and the queue of expected reply words.
  class responder_scoreboard;
    logic [5:0]  dev_addr;
    logic [31:0] btn_mask;
    logic [10:0] nbytes;
    logic [7:0]  xsum;
    logic [7:0]  hdr[4];
    logic [31:0] func;
    logic [7:0]  power;
    logic [15:0] pad_buttons;
    logic [7:0]  axes[6];
    logic [7:0]  rumble;
    out_item_t   pending[$];

    function void clear();
      dev_addr = DevAddrReset;
      btn_mask = ButtonsReset;
      nbytes = '0;
      xsum = '0;
      foreach (hdr[i]) hdr[i] = '0;
      func = '0;
      power = '0;
      pad_buttons = 16'hFFFF;
      axes[0] = '0;
      axes[1] = '0;
      for (int i = 2; i < 6; i++) axes[i] = AxisCentre;
      rumble = '0;
      pending.delete();
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] val);
      if (idx == RegDevAddr) dev_addr = val[5:0];
      else btn_mask = val;
    endfunction

    function logic [31:0] header(logic [7:0] cmd, logic [7:0] len);
      logic [7:0] port;
      port = hdr[1] & PortBits;
      return {len, port | {2'b00, dev_addr}, port, cmd};
    endfunction

    function void emit(logic [31:0] w[$]);
      logic [31:0] x;
      out_item_t o;
      x = '0;
      for (int i = 1; i < w.size(); i++) x ^= w[i];
      x ^= x << 16;
      x ^= x << 8;
      w.push_back(x);
      foreach (w[i]) begin
        o.tx_word = w[i];
        o.last_word = (i == w.size() - 1);
        o.rumble_power = rumble;
        pending.push_back(o);
      end
    endfunction

    function void reply(logic [10:0] sz);
      logic [31:0] w[$];
      if (sz[1:0] != 2'd1) return;
      if (32'(sz) - 1 != (32'(hdr[0]) + 1) * 4) return;
      if ((hdr[2] & PeriphBits) != {2'b00, dev_addr}) return;
      case (hdr[3])
        CmdReset: begin
          w = '{32'd19, header(CmdAck, 8'd0)};
          emit(w);
        end
        CmdDevReq: begin
          w = '{32'd467, header(CmdInfo, 8'd28), FuncWord,
                {btn_mask[7:0], btn_mask[15:8], btn_mask[23:16], btn_mask[31:24]},
                32'd0, 32'd0};
          w = {w, info_text()};
          emit(w);
        end
        CmdGetCond: begin
          if (hdr[0] >= 1 && func == FuncStatus) begin
            w = '{32'd67, header(CmdStatus, 8'd3), FuncWord,
                  {axes[1], axes[0], pad_buttons},
                  {axes[5], axes[4], axes[3], axes[2]}};
            emit(w);
          end
        end
        CmdSetCond: begin
          if (hdr[0] >= 2 && func == FuncRumble) rumble = power;
          w = '{32'd19, header(CmdAck, 8'd0)};
          emit(w);
        end
        default: ;
      endcase
    endfunction

    function void note_input(in_item_t it);
      logic [10:0] sz;
      if (it.opcode) begin
        pad_buttons = it.buttons;
        axes = '{it.right_trigger, it.left_trigger, it.stick_x, it.stick_y,
                 it.stick2_x, it.stick2_y};
        return;
      end
      if (nbytes < 4) hdr[nbytes] = it.bus_byte;
      else if (nbytes < 8) func[8*(nbytes-4) +: 8] = it.bus_byte;
      else if (nbytes == 10) power = it.bus_byte;
      xsum ^= it.bus_byte;
      if (nbytes < CountMax) nbytes++;
      if (!it.last_byte) return;
      sz = nbytes;
      nbytes = '0;
      if (xsum != 0) begin
        xsum = '0;
        return;
      end
      reply(sz);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got.tx_word, '0);
        return;
      end
      want = pending.pop_front();
      if (got.tx_word !== want.tx_word) report("tx_word", got.tx_word, want.tx_word);
      if (got.last_word !== want.last_word)
        report("last_word", 32'(got.last_word), 32'(want.last_word));
      if (got.rumble_power !== want.rumble_power)
        report("rumble_power", 32'(got.rumble_power), 32'(want.rumble_power));
    endtask
  endclass

  responder_scoreboard sb = new();

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Keep push high across back-to-back items; drop it only for a gap.
  task automatic send_item(in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_input(it);
  endtask

  task automatic send_byte(logic [7:0] b, logic eop);
    in_item_t it;
    it = '0;
    it.opcode = 1'b0;
    it.bus_byte = b;
    it.last_byte = eop;
    it.buttons = 16'($urandom());
    {it.right_trigger, it.left_trigger, it.stick_x, it.stick_y} = $urandom();
    send_item(it);
  endtask

  task automatic send_pad(logic [15:0] btn, logic [7:0] ax);
    in_item_t it;
    it = '0;
    it.opcode = 1'b1;
    it.bus_byte = 8'($urandom());
    it.last_byte = 1'($urandom());
    it.buttons = btn;
    {it.right_trigger, it.left_trigger, it.stick_x} = {ax, ~ax, 8'($urandom())};
    {it.stick_y, it.stick2_x, it.stick2_y} = 24'($urandom());
    send_item(it);
  endtask

  // Send a packet: header, function word, payload and check byte.
  // A nonzero corrupt flips the check byte.
  task automatic send_packet(logic [7:0] cmd, logic [7:0] dst, logic [7:0] org,
                             logic [31:0] fn, int nwords, logic [7:0] pwr,
                             logic [7:0] corrupt);
    logic [7:0] b[$];
    logic [7:0] x;
    b = '{8'(nwords), org, dst, cmd};
    for (int i = 0; i < nwords * 4; i++) begin
      if (i < 4) b.push_back(fn[8*i +: 8]);
      else if (i == 6) b.push_back(pwr);
      else b.push_back(8'($urandom()));
    end
    x = '0;
    foreach (b[i]) x ^= b[i];
    b.push_back(x ^ corrupt);
    foreach (b[i]) send_byte(b[i], i == b.size() - 1);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_packet();
    logic [7:0] cmds[4];
    logic [7:0] cmd, dst, len;
    logic [31:0] fn;
    int r, nw;
    cmds = '{CmdDevReq, CmdReset, CmdGetCond, CmdSetCond};
    r = $urandom_range(0, 99);
    cmd = cmds[$urandom_range(0, 3)];
    if (r < 4) cmd = 8'($urandom());
    dst = {2'($urandom()), sb.dev_addr};
    if (r >= 4 && r < 8) dst = 8'($urandom());
    nw = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0: fn = FuncStatus;
      1: fn = FuncRumble;
      2: fn = 32'($urandom());
      default: fn = (cmd == CmdGetCond) ? FuncStatus : FuncRumble;
    endcase
    if (r >= 8 && r < 12) begin
      // broken framing: random length byte, not matched to the bytes sent
      len = 8'($urandom_range(0, 5));
      send_byte(len, 1'b0);
      repeat ($urandom_range(0, 9)) send_byte(8'($urandom()), 1'b0);
      send_byte(8'($urandom()), 1'b1);
      return;
    end
    send_packet(cmd, dst, 8'($urandom()), fn, nw, 8'($urandom()),
                (r >= 12 && r < 16) ? 8'($urandom_range(1, 255)) : 8'h00);
  endtask

  // Result side: random pops, with one long hold-off on request.
  initial begin
    out_item_t got;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = out_o;
        sb.check_result(got);
      end
      if (hold_off || ($urandom_range(0, 99) < 30 && $urandom_range(0, 9) != 0)) pop <= 1'b0;
      else if ($urandom_range(0, 99) < 3) pop <= 1'b0;
      else pop <= 1'b1;
    end
  end

  // Long receiver stall, counted here, while the sender keeps pushing.
  initial begin
    wait (rst_ni);
    repeat (20) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog on stretches with no transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    sb.clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command, the limits of the fields and each rejection.
    send_packet(CmdReset, 8'h20, 8'hC0, 32'h0, 0, 8'h0, 8'h00);
    send_packet(CmdDevReq, 8'hE0, 8'h40, 32'h0, 0, 8'h0, 8'h00);
    send_pad(16'h0000, 8'hFF);
    send_packet(CmdGetCond, 8'h20, 8'h80, FuncStatus, 1, 8'h0, 8'h00);
    send_packet(CmdGetCond, 8'h20, 8'h80, FuncStatus, 0, 8'h0, 8'h00);
    send_packet(CmdGetCond, 8'h20, 8'h80, FuncRumble, 2, 8'h0, 8'h00);
    send_packet(CmdSetCond, 8'h20, 8'h00, FuncRumble, 3, 8'hFF, 8'h00);
    send_packet(CmdSetCond, 8'h20, 8'h00, FuncRumble, 1, 8'h11, 8'h00);
    send_packet(CmdSetCond, 8'h20, 8'h00, FuncStatus, 2, 8'h22, 8'h00);
    send_packet(CmdReset, 8'h20, 8'hC0, 32'h0, 0, 8'h0, 8'h5A);
    send_packet(CmdReset, 8'h21, 8'hC0, 32'h0, 0, 8'h0, 8'h00);
    send_packet(8'hFF, 8'h20, 8'h00, 32'h0, 0, 8'h0, 8'h00);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_pad(16'hFFFF, 8'h00);
    send_packet(CmdGetCond, 8'h20, 8'h00, FuncStatus, 1, 8'h0, 8'h00);
    wait_drain();

    write_cfg(RegDevAddr, 32'd0);
    write_cfg(RegButtons, 32'hFFFFFFFF);
    send_packet(CmdDevReq, 8'hC0, 8'hFF, 32'h0, 0, 8'h0, 8'h00);
    wait_drain();
    write_cfg(RegDevAddr, 32'd63);
    write_cfg(RegButtons, 32'h0);
    send_packet(CmdDevReq, 8'h3F, 8'h00, 32'h0, 0, 8'h0, 8'h00);
    send_packet(CmdReset, 8'hFF, 8'h3F, 32'h0, 0, 8'h0, 8'h00);

    for (int phase = 0; phase < 3; phase++) begin
      wait_drain();
      write_cfg(RegDevAddr, 32'($urandom()));
      write_cfg(RegButtons, $urandom());
      for (int n = 0; n < 4; n++) begin
        if ($urandom_range(0, 3) == 0) send_pad(16'($urandom()), 8'($urandom()));
        else random_packet();
      end
    end

    wait_drain();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
